[hdl/mfu_pkg.sv]
// shared types and constants for the mfu page replacement block
// controller state, controller/datapath command and status structs, port widths
// no dependencies
package mfu_pkg;

  // fixed port field widths
  localparam int PAGE_W    = 16;
  localparam int FRAME_W   = 3;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 4;
  localparam int S_TDATA_W = 16;
  // hit + frame_index + victim_valid + victim_page + fault_total, padded to bytes
  localparam int M_FIELD_W = 1 + FRAME_W + 1 + PAGE_W + FAULT_W;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } mfu_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch page, advance reference time, restart scan
    logic step;    // examine the frame at the scan index
    logic commit;  // update the frame table and load the result register
  } mfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index is on the last managed frame
    logic out_free;   // result register can take a new result this cycle
  } mfu_stat_t;

endpackage

[hdl/mfu_ctrl.sv]
// controller state machine for the mfu page replacement block
// sequences accept, frame scan and commit; drives the input ready
// depends on mfu_pkg
module mfu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  mfu_pkg::mfu_stat_t stat,
  output mfu_pkg::mfu_cmd_t  cmd
);

  mfu_pkg::mfu_state_t state;
  mfu_pkg::mfu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mfu_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = mfu_pkg::ST_SCAN;
        end
      end
      mfu_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = mfu_pkg::ST_COMMIT;
        end
      end
      mfu_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          state_next = mfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfu_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      mfu_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        s_tready  = !rst;
        cmd.start = s_tvalid && !rst;
      end
      mfu_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
      end
      mfu_pkg::ST_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // a transaction is followed by a scan
  a_start_to_scan: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == mfu_pkg::ST_SCAN))
    else $error("accepted reference did not start a scan");

  // scan ends on the last managed frame
  a_scan_to_commit: assert property (@(posedge clk) disable iff (rst)
    (state == mfu_pkg::ST_SCAN && stat.scan_last) |=> (state == mfu_pkg::ST_COMMIT))
    else $error("scan did not hand over to commit");

  // only one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.step, cmd.commit}))
    else $error("overlapping datapath commands");

endmodule

[hdl/mfu_dpath.sv]
// datapath for the mfu page replacement block
// frame table, scan for match and victim, counters and result register
// depends on mfu_pkg; driven by mfu_ctrl
module mfu_dpath #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mfu_pkg::mfu_cmd_t                cmd,
  output mfu_pkg::mfu_stat_t               stat,
  input  logic [mfu_pkg::PAGE_W-1:0]       page,
  input  logic                             cfg_valid,
  input  logic [mfu_pkg::CFG_W-1:0]        cfg_data,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mfu_pkg::M_TDATA_W-1:0]    m_tdata
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int MW = $clog2(NUM_FRAMES + 1);
  localparam logic [mfu_pkg::CFG_W-1:0] CFG_RESET =
    (NUM_FRAMES < 8) ? mfu_pkg::CFG_W'(NUM_FRAMES) : mfu_pkg::CFG_W'(8);

  // frame table
  logic [PAGE_BITS-1:0]  page_tag      [NUM_FRAMES];
  logic                  tag_valid     [NUM_FRAMES];
  logic [COUNT_BITS-1:0] use_count     [NUM_FRAMES];
  logic [TIME_BITS-1:0]  last_use_time [NUM_FRAMES];

  logic [mfu_pkg::CFG_W-1:0]   frames_in_use;
  logic [MW-1:0]               fill_pointer;
  logic [mfu_pkg::FAULT_W-1:0] fault_count;
  logic [TIME_BITS-1:0]        reference_time;

  // per-reference working registers
  logic [PAGE_BITS-1:0]  cur_page;
  logic [MW-1:0]         scan_idx;
  logic                  found;
  logic [FW-1:0]         hit_slot;
  logic [COUNT_BITS-1:0] hit_count;
  logic [FW-1:0]         best_idx;
  logic [COUNT_BITS-1:0] best_count;
  logic [TIME_BITS-1:0]  best_time;
  logic                  best_valid;
  logic [PAGE_BITS-1:0]  best_tag;

  // result register
  logic                       out_hit;
  logic [mfu_pkg::FRAME_W-1:0] out_frame;
  logic                       out_vvalid;
  logic [mfu_pkg::PAGE_W-1:0] out_vpage;

  logic [MW-1:0]         managed;
  logic [FW-1:0]         e_idx;
  logic                  e_match;
  logic                  e_better;
  logic                  do_fill;
  logic [FW-1:0]         slot;
  logic                  evict;
  logic [COUNT_BITS-1:0] hit_count_next;
  logic [mfu_pkg::FAULT_W-1:0] fault_count_next;
  logic [TIME_BITS-1:0]  reference_time_next;

  // clamp the register to 1..NUM_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      managed = MW'(1);
    end else if (32'(frames_in_use) > NUM_FRAMES) begin
      managed = MW'(NUM_FRAMES);
    end else begin
      managed = MW'(frames_in_use);
    end
  end

  assign e_idx    = scan_idx[FW-1:0];
  assign e_match  = tag_valid[e_idx] && (page_tag[e_idx] == cur_page);
  assign e_better = (use_count[e_idx] > best_count) ||
                    ((use_count[e_idx] == best_count) && (last_use_time[e_idx] < best_time));

  assign do_fill = !found && (fill_pointer < managed);
  always_comb begin
    if (found) begin
      slot = hit_slot;
    end else if (do_fill) begin
      slot = fill_pointer[FW-1:0];
    end else begin
      slot = best_idx;
    end
  end
  assign evict = !found && !do_fill && best_valid;

  assign hit_count_next      = (hit_count == '1) ? hit_count : hit_count + COUNT_BITS'(1);
  assign fault_count_next    = (fault_count == '1) ? fault_count
                                                   : fault_count + mfu_pkg::FAULT_W'(1);
  assign reference_time_next = (reference_time == '1) ? reference_time
                                                      : reference_time + TIME_BITS'(1);

  assign stat.scan_last = (scan_idx == managed - MW'(1));
  assign stat.out_free  = !m_tvalid || m_tready;

  // control state and table contents with a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        tag_valid[i]     <= 1'b0;
        use_count[i]     <= '0;
        last_use_time[i] <= '0;
      end
      frames_in_use  <= CFG_RESET;
      fill_pointer   <= '0;
      fault_count    <= '0;
      reference_time <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frames_in_use <= cfg_data;
      end
      if (cmd.start) begin
        reference_time <= reference_time_next;
      end
      if (cmd.commit) begin
        last_use_time[slot] <= reference_time;
        if (found) begin
          use_count[slot] <= hit_count_next;
        end else begin
          use_count[slot] <= COUNT_BITS'(1);
          tag_valid[slot] <= 1'b1;
          fault_count     <= fault_count_next;
          if (do_fill) begin
            fill_pointer <= fill_pointer + MW'(1);
          end
        end
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_page <= PAGE_BITS'(page);
      scan_idx <= '0;
      found    <= 1'b0;
    end
    if (cmd.step) begin
      scan_idx <= scan_idx + MW'(1);
      if (e_match && !found) begin
        found     <= 1'b1;
        hit_slot  <= e_idx;
        hit_count <= use_count[e_idx];
      end
      if (scan_idx == '0 || e_better) begin
        best_idx   <= e_idx;
        best_count <= use_count[e_idx];
        best_time  <= last_use_time[e_idx];
        best_valid <= tag_valid[e_idx];
        best_tag   <= page_tag[e_idx];
      end
    end
    if (cmd.commit) begin
      if (!found) begin
        page_tag[slot] <= cur_page;
      end
      out_hit    <= found;
      out_frame  <= mfu_pkg::FRAME_W'(slot);
      out_vvalid <= evict;
      out_vpage  <= evict ? mfu_pkg::PAGE_W'(best_tag) : '0;
    end
  end

  assign m_tdata = {{mfu_pkg::M_PAD_W{1'b0}}, fault_count, out_vpage, out_vvalid,
                    out_frame, out_hit};

  // a hit never evicts
  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_hit) |-> !out_vvalid)
    else $error("hit result reports an eviction");

  // fault total moves only on a committed miss
  a_fault_stable: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit && !found) |-> $stable(fault_count))
    else $error("fault count changed outside a miss commit");

  // fill pointer never runs past the built frame count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_pointer) <= NUM_FRAMES)
    else $error("fill pointer beyond frame table");

endmodule

[hdl/mfu_page_replacement.sv]
// most-frequently-used page replacement unit, top level
// instantiates mfu_ctrl (state machine) and mfu_dpath (frame table and scan)
// depends on mfu_pkg
//
// Each transaction on the s_ side is one page reference; each produces exactly
// one result on the m_ side saying whether the page was resident, which frame
// holds it now, which page (if any) was evicted and the running fault total.
// Frames are filled in order while empty; once all managed frames are full the
// frame with the highest use count is replaced, the oldest last use breaking
// ties and then the lowest index. Use counts, the reference time and the fault
// total saturate. One reference is handled at a time: it is accepted, then the
// frame table is scanned sequentially, one managed frame at a time (match and
// victim search share that single pass), and then it is committed. The result
// sits in an output register, so a finished result waiting on m_tready does not
// stop the next reference being accepted and scanned; only its commit waits.
// frames_in_use may only be written while no reference is in flight; 0 behaves
// as 1 and values above NUM_FRAMES as NUM_FRAMES. The config port is always
// ready. s_tready is low while reset is held.
module mfu_page_replacement #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // reference input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mfu_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] page
  // result output
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] hit, [3:1] frame_index, [4] victim_valid, [20:5] victim_page,
  // [52:21] fault_total, [55:53] zero
  output logic [mfu_pkg::M_TDATA_W-1:0] m_tdata,
  // frames_in_use register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfu_pkg::CFG_W-1:0]     cfg_data    // [3:0] frames_in_use
);

  mfu_pkg::mfu_cmd_t  cmd;
  mfu_pkg::mfu_stat_t stat;

  // register writes complete immediately
  assign cfg_ready = 1'b1;

  mfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfu_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .page      (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
